>>> design/assert_macros.svh
// Assertion macros used by the output stage of the signed gadget digit decomposition RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> design/sgdd_pkg.sv
// Types and constants of the signed gadget digit decomposition block.
package sgdd_pkg;

    localparam int MAX_DIGITS    = 8;
    localparam int COEFF_BITS    = 32;
    localparam int LOG_BASE_MAX  = 16;

    localparam int Q_W           = 32;
    localparam int LOG_W         = 5;
    localparam int COUNT_W       = 4;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int DIGIT_VALUE_W = 32;
    localparam int DIGIT_INDEX_W = 4;

    localparam int DIGIT_W  = LOG_BASE_MAX;
    localparam int MAGN_W   = (COEFF_BITS > Q_W) ? COEFF_BITS : Q_W;
    localparam int VALUE_W  = MAGN_W + 2;
    localparam int RES_MAX  = 2 * (MAX_DIGITS - 1);
    localparam int POS_W    = (RES_MAX > 1) ? $clog2(RES_MAX) : 1;
    localparam int SLOT_W   = $clog2(MAX_DIGITS);
    localparam int TOTAL_W  = $clog2(MAX_DIGITS + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_Q   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOG_BASE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_MODE   = 2'd3;

    localparam logic [Q_W-1:0]     MODULUS_Q_RESET   = 32'd1024;
    localparam logic [LOG_W-1:0]   LOG_BASE_RESET    = 5'd7;
    localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 4'd3;
    localparam logic               PAIR_MODE_RESET   = 1'b1;

    typedef logic [DIGIT_W-1:0] sdigit_t;

    typedef struct packed {
        logic [COEFF_BITS-1:0] coeff_first;
        logic [COEFF_BITS-1:0] coeff_second;
    } coeff_t;

    typedef struct packed {
        logic [DIGIT_VALUE_W-1:0] digit_value;
        logic [DIGIT_INDEX_W-1:0] digit_index;
        logic                     last_digit;
    } result_t;

    typedef struct packed {
        logic [VALUE_W-1:0]             v0;
        logic [VALUE_W-1:0]             v1;
        sdigit_t [MAX_DIGITS-1:0]       d0;
        sdigit_t [MAX_DIGITS-1:0]       d1;
    } chain_t;

    typedef struct packed {
        logic [Q_W-1:0]   q;
        logic [LOG_W-1:0] shift;
        logic             pair;
        logic             active;
        logic [POS_W-1:0] last_pos;
    } cfg_t;

endpackage

>>> design/sgdd_lift.sv
// Entry stage: lifts each coefficient to its centered signed value.
module sgdd_lift
    import sgdd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    input  coeff_t in_data,
    output logic   in_ready,
    output logic   out_valid,
    output chain_t out_data,
    input  logic   out_ready
);

    logic   valid_reg;
    chain_t data_reg;
    chain_t data_next;

    function automatic logic [VALUE_W-1:0] center(
        input logic [COEFF_BITS-1:0] t,
        input logic [Q_W-1:0]        q
    );
        logic [MAGN_W-1:0] tm;
        logic [MAGN_W-1:0] qm;
        logic [MAGN_W-1:0] half;
        tm   = MAGN_W'(t);
        qm   = MAGN_W'(q);
        half = qm >> 1;
        if (tm < half)
        begin
            return {2'b00, tm};
        end
        return {2'b00, tm} - {2'b00, qm};
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next    = '0;
        data_next.v0 = center(in_data.coeff_first, cfg.q);
        data_next.v1 = center(in_data.coeff_second, cfg.q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            // Items that yield no digits are taken and dropped here.
            valid_reg <= in_valid && cfg.active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> design/sgdd_cell.sv
// One digit cell: removes the lowest signed digit of both coefficients.
module sgdd_cell
    import sgdd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    input  chain_t in_data,
    output logic   in_ready,
    output logic   out_valid,
    output chain_t out_data,
    input  logic   out_ready
);

    typedef struct packed {
        sdigit_t            digit;
        logic [VALUE_W-1:0] rest;
    } step_t;

    logic   valid_reg;
    chain_t data_reg;
    chain_t data_next;
    step_t  step0;
    step_t  step1;

    function automatic step_t take_digit(
        input logic [VALUE_W-1:0] v,
        input logic [LOG_W-1:0]   g
    );
        logic [DIGIT_W:0]          one;
        logic [DIGIT_W-1:0]        mask;
        logic [DIGIT_W-1:0]        low;
        logic                      msb;
        logic signed [VALUE_W-1:0] sv;
        logic signed [VALUE_W-1:0] sh;
        step_t                     s;
        one   = {{DIGIT_W{1'b0}}, 1'b1};
        mask  = DIGIT_W'((one << g) - one);
        low   = v[DIGIT_W-1:0] & mask;
        msb   = |(low & (mask ^ (mask >> 1)));
        sv    = $signed(v);
        sh    = sv >>> g;
        s.digit = msb ? (low | ~mask) : low;
        s.rest  = $unsigned(sh) + {{(VALUE_W-1){1'b0}}, msb};
        return s;
    endfunction

    assign in_ready = !valid_reg || out_ready;
    assign step0    = take_digit(in_data.v0, cfg.shift);
    assign step1    = take_digit(in_data.v1, cfg.shift);

    always_comb
    begin
        data_next    = in_data;
        data_next.v0 = step0.rest;
        data_next.v1 = step1.rest;
        data_next.d0 = {step0.digit, in_data.d0[MAX_DIGITS-1:1]};
        data_next.d1 = {step1.digit, in_data.d1[MAX_DIGITS-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> design/sgdd_serial.sv
// Output stage: sends the kept digits of one item, one per cycle while result_stall is low.
`include "assert_macros.svh"

module sgdd_serial
    import sgdd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    input  chain_t  in_data,
    output logic    in_ready,
    output logic    result_valid,
    output result_t result,
    input  logic    result_stall
);

    logic             buf_valid_reg;
    chain_t           buf_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          out_next;

    logic              take;
    logic              fire;
    logic              is_last;
    logic              second;
    logic [POS_W-1:0]  j_pos;
    logic [SLOT_W-1:0] slot;
    sdigit_t           r;
    logic [DIGIT_VALUE_W-1:0] r_ext;

    assign take     = !out_valid_reg || !result_stall;
    assign fire     = buf_valid_reg && take;
    assign is_last  = (pos_reg == cfg.last_pos);
    assign in_ready = !buf_valid_reg || (fire && is_last);

    // Slot zero holds the dropped lowest digit.
    assign second = cfg.pair && pos_reg[0];
    assign j_pos  = cfg.pair ? (pos_reg >> 1) : pos_reg;
    assign slot   = SLOT_W'(j_pos + {{(POS_W-1){1'b0}}, 1'b1});
    assign r      = second ? buf_reg.d1[slot] : buf_reg.d0[slot];
    assign r_ext  = {{(DIGIT_VALUE_W-DIGIT_W){r[DIGIT_W-1]}}, r};

    always_comb
    begin
        out_next.digit_value = r[DIGIT_W-1] ? (r_ext + DIGIT_VALUE_W'(cfg.q)) : r_ext;
        out_next.digit_index = DIGIT_INDEX_W'(pos_reg);
        out_next.last_digit  = is_last;
        pos_next             = is_last ? '0 : (pos_reg + {{(POS_W-1){1'b0}}, 1'b1});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                buf_valid_reg <= in_valid;
            end
            if (fire)
            begin
                pos_reg <= pos_next;
            end
            if (take)
            begin
                out_valid_reg <= buf_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            buf_reg <= in_data;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `ASSERT_NEVER(a_pos_in_range, clk, rst_n, buf_valid_reg && (pos_reg > cfg.last_pos))
    `ASSERT_ALWAYS(a_new_item_starts_at_zero, clk, rst_n, $rose(buf_valid_reg) |-> (pos_reg == '0))
    `ASSERT_ALWAYS(a_empty_after_last, clk, rst_n, (fire && is_last && !in_valid) |=> !buf_valid_reg)

endmodule

>>> design/signed_gadget_digit_decompose.sv
// Top level of the signed gadget digit decomposition block.
//
// Each transfer on the coeff channel carries one coefficient (two in pair mode).
// Each coefficient is centered, cut into signed digits of log_base bits, the
// lowest digit is dropped and the next digit_count-1 digits are sent on the
// digit channel, negative ones with Q added, with last_digit on the final one.
// In pair mode digits of the two coefficients alternate at even and odd indices.
// The data path is an entry stage, a row of MAX_DIGITS digit cells that each
// strip one digit, and an output stage with its own output register.
// The output stage sends one digit per cycle while digit_stall is low, so an
// item gives digit_count-1 digits, or 2*(digit_count-1) in pair mode (four at reset).
// Items with a digit count below two are taken and give no digits.
// The next item is taken while earlier ones are still in the cells.
// Reset empties every stage and loads the register reset values.
// A stall on the digit channel holds the output and backs the row of cells up
// stage by stage until coeff_stall rises.
// Configuration must be written only while the block is empty; the block itself does not enforce this.
module signed_gadget_digit_decompose
    import sgdd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   coeff_valid,
    output logic                   coeff_stall,
    input  coeff_t                 coeff,
    output logic                   digit_valid,
    input  logic                   digit_stall,
    output result_t                digit
);

    logic [Q_W-1:0]     modulus_q_reg;
    logic [LOG_W-1:0]   log_base_reg;
    logic [COUNT_W-1:0] digit_count_reg;
    logic               pair_mode_reg;

    cfg_t               cfg;
    logic [TOTAL_W-1:0] total;
    logic [POS_W:0]     kept;

    logic                  lift_ready;
    logic [MAX_DIGITS:0]   stage_valid;
    logic [MAX_DIGITS:0]   stage_ready;
    chain_t [MAX_DIGITS:0] stage_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_q_reg   <= MODULUS_Q_RESET;
            log_base_reg    <= LOG_BASE_RESET;
            digit_count_reg <= DIGIT_COUNT_RESET;
            pair_mode_reg   <= PAIR_MODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS_Q:   modulus_q_reg   <= cfg_data[Q_W-1:0];
                REG_LOG_BASE:    log_base_reg    <= cfg_data[LOG_W-1:0];
                REG_DIGIT_COUNT: digit_count_reg <= cfg_data[COUNT_W-1:0];
                REG_PAIR_MODE:   pair_mode_reg   <= cfg_data[0];
                default:         modulus_q_reg   <= modulus_q_reg;
            endcase
        end
    end

    always_comb
    begin
        total = (int'(digit_count_reg) > MAX_DIGITS) ? TOTAL_W'(MAX_DIGITS)
                                                    : TOTAL_W'(digit_count_reg);
        kept  = (POS_W + 1)'(total) - {{POS_W{1'b0}}, 1'b1};
        cfg.q      = modulus_q_reg;
        cfg.pair   = pair_mode_reg;
        cfg.active = (total >= TOTAL_W'(2));
        if (log_base_reg == '0)
        begin
            cfg.shift = LOG_W'(1);
        end
        else if (int'(log_base_reg) > LOG_BASE_MAX)
        begin
            cfg.shift = LOG_W'(LOG_BASE_MAX);
        end
        else
        begin
            cfg.shift = log_base_reg;
        end
        cfg.last_pos = pair_mode_reg ? POS_W'((kept << 1) - {{POS_W{1'b0}}, 1'b1})
                                     : POS_W'(kept - {{POS_W{1'b0}}, 1'b1});
    end

    assign coeff_stall = !lift_ready;

    sgdd_lift u_lift (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (coeff_valid),
        .in_data   (coeff),
        .in_ready  (lift_ready),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0]),
        .out_ready (stage_ready[0])
    );

    for (genvar k = 0; k < MAX_DIGITS; k++)
    begin : g_cell
        sgdd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (cfg),
            .in_valid  (stage_valid[k]),
            .in_data   (stage_data[k]),
            .in_ready  (stage_ready[k]),
            .out_valid (stage_valid[k+1]),
            .out_data  (stage_data[k+1]),
            .out_ready (stage_ready[k+1])
        );
    end

    sgdd_serial u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (stage_valid[MAX_DIGITS]),
        .in_data      (stage_data[MAX_DIGITS]),
        .in_ready     (stage_ready[MAX_DIGITS]),
        .result_valid (digit_valid),
        .result       (digit),
        .result_stall (digit_stall)
    );

endmodule

>>> sim/tb.sv
// Self-checking testbench for the signed gadget digit decomposition block.
`timescale 1ns / 1ps

module tb;
    import sgdd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 25;
    localparam int DIR_ROWS     = 19;

    typedef struct packed {
        logic                  new_cfg;
        logic [Q_W-1:0]        q;
        logic [LOG_W-1:0]      lb;
        logic [COUNT_W-1:0]    dc;
        logic                  pm;
        logic [COEFF_BITS-1:0] c_first;
        logic [COEFF_BITS-1:0] c_second;
        logic                  typed;
        logic [0:3][DIGIT_VALUE_W-1:0] vals;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   coeff_valid;
    logic                   coeff_stall;
    coeff_t                 coeff;
    logic                   digit_valid;
    logic                   digit_stall;
    result_t                digit;

    logic [Q_W-1:0]     cur_q;
    logic [LOG_W-1:0]   cur_log_base;
    logic [COUNT_W-1:0] cur_digit_count;
    logic               cur_pair;

    result_t expected_digits[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      pressure_go = 1'b0;
    bit      no_gaps = 1'b0;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'd0, 32'd0, 32'd0, 32'd0}},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'h0000_01FF, 32'h0000_0200, 1'b1,
          '{32'd4, 32'd1020, 32'd0, 32'd0}},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'h0000_0200, 32'h0000_01FF, 1'b1,
          '{32'd1020, 32'd4, 32'd0, 32'd0}},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'h0000_03FF, 32'h0000_0001, 1'b1,
          '{32'd0, 32'd0, 32'd0, 32'd0}},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0400, 1'b0, '0},
        '{1'b1, 32'hFFFF_FFFF, 5'd16, 4'd8, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
        '{1'b1, 32'd2, 5'd1, 4'd15, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, '0},
        '{1'b1, 32'd0, 5'd0, 4'd2, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'h0000_0000, 32'h0000_0001, 1'b0, '0},
        '{1'b1, 32'd1, 5'd31, 4'd1, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b1, 32'd1000003, 5'd17, 4'd0, 1'b0, 32'd5, 32'd1000002, 1'b0, '0},
        '{1'b1, 32'h8000_0000, 5'd5, 4'd4, 1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b0, 32'd0, 5'd0, 4'd0, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0}
    };

    signed_gadget_digit_decompose u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .coeff_valid (coeff_valid),
        .coeff_stall (coeff_stall),
        .coeff       (coeff),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit       (digit)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic longint center_lift(logic [COEFF_BITS-1:0] t);
        if (t < (cur_q >> 1))
            return longint'({32'b0, t});
        return longint'({32'b0, t}) - longint'({32'b0, cur_q});
    endfunction

    function automatic longint strip_digit(inout longint v, input int g);
        longint base;
        longint low;
        longint r;
        base = longint'(1) << g;
        low  = v & (base - 1);
        r    = low;
        if (low[g-1])
            r = low - base;
        v = (v - r) >>> g;
        return r;
    endfunction

    function automatic logic [DIGIT_VALUE_W-1:0] wrap_digit(longint r);
        longint m;
        m = r;
        if (m < 0)
            m = m + longint'({32'b0, cur_q});
        return m[DIGIT_VALUE_W-1:0];
    endfunction

    function automatic void decompose(coeff_t c);
        int      g;
        int      total;
        longint  v0;
        longint  v1;
        result_t res;
        g     = int'(cur_log_base);
        total = int'(cur_digit_count);
        if (g < 1)
            g = 1;
        if (g > LOG_BASE_MAX)
            g = LOG_BASE_MAX;
        if (total > MAX_DIGITS)
            total = MAX_DIGITS;
        if (total < 2)
            return;
        v0 = center_lift(c.coeff_first);
        v1 = center_lift(c.coeff_second);
        void'(strip_digit(v0, g));
        void'(strip_digit(v1, g));
        for (int j = 0; j < total - 1; j++)
        begin
            res.digit_value = wrap_digit(strip_digit(v0, g));
            res.digit_index = cur_pair ? DIGIT_INDEX_W'(2 * j) : DIGIT_INDEX_W'(j);
            res.last_digit  = (j == total - 2) && !cur_pair;
            expected_digits.push_back(res);
            if (cur_pair)
            begin
                res.digit_value = wrap_digit(strip_digit(v1, g));
                res.digit_index = DIGIT_INDEX_W'(2 * j + 1);
                res.last_digit  = (j == total - 2);
                expected_digits.push_back(res);
            end
        end
    endfunction

    task automatic send_item(coeff_t c, logic typed, logic [0:3][DIGIT_VALUE_W-1:0] vals);
        result_t res;
        while (!no_gaps && $urandom_range(0, 99) < 9)
        begin
            coeff_valid <= 1'b0;
            @(posedge clk);
        end
        coeff_valid <= 1'b1;
        coeff       <= c;
        @(posedge clk);
        while (coeff_stall)
            @(posedge clk);
        if (typed)
        begin
            for (int k = 0; k < 4; k++)
            begin
                res.digit_value = vals[k];
                res.digit_index = DIGIT_INDEX_W'(k);
                res.last_digit  = (k == 3);
                expected_digits.push_back(res);
            end
        end
        else
            decompose(c);
    endtask

    task automatic wait_idle();
        coeff_valid <= 1'b0;
        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic [Q_W-1:0] q, logic [LOG_W-1:0] lb,
                                logic [COUNT_W-1:0] dc, logic pm);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODULUS_Q;
        cfg_data  <= q;
        @(posedge clk);
        cfg_index <= REG_LOG_BASE;
        cfg_data  <= CFG_DATA_W'(lb);
        @(posedge clk);
        cfg_index <= REG_DIGIT_COUNT;
        cfg_data  <= CFG_DATA_W'(dc);
        @(posedge clk);
        cfg_index <= REG_PAIR_MODE;
        cfg_data  <= CFG_DATA_W'(pm);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_q           = q;
        cur_log_base    = lb;
        cur_digit_count = dc;
        cur_pair        = pm;
    endtask

    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        digit_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                digit_stall <= 1'b1;
            end
            else if (!no_gaps && $urandom_range(0, 99) < 9)
                digit_stall <= 1'b1;
            else
                digit_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && digit_valid && !digit_stall)
        begin
            if (expected_digits.size() == 0)
            begin
                $error("unexpected digit transfer: value %0h index %0d last %0b",
                       digit.digit_value, digit.digit_index, digit.last_digit);
                mismatch_count++;
            end
            else
            begin
                want = expected_digits.pop_front();
                if (digit.digit_value !== want.digit_value)
                begin
                    $error("digit_value: expected %0h, got %0h",
                           want.digit_value, digit.digit_value);
                    mismatch_count++;
                end
                if (digit.digit_index !== want.digit_index)
                begin
                    $error("digit_index: expected %0d, got %0d",
                           want.digit_index, digit.digit_index);
                    mismatch_count++;
                end
                if (digit.last_digit !== want.last_digit)
                begin
                    $error("last_digit: expected %0b, got %0b",
                           want.last_digit, digit.last_digit);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        coeff_t             c;
        logic [Q_W-1:0]     q;
        logic [LOG_W-1:0]   lb;
        logic [COUNT_W-1:0] dc;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_MODULUS_Q;
        cfg_data    <= '0;
        coeff_valid <= 1'b0;
        coeff       <= '0;
        cur_q           = MODULUS_Q_RESET;
        cur_log_base    = LOG_BASE_RESET;
        cur_digit_count = DIGIT_COUNT_RESET;
        cur_pair        = PAIR_MODE_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].new_cfg)
            begin
                wait_idle();
                write_config(directed_rows[i].q, directed_rows[i].lb,
                             directed_rows[i].dc, directed_rows[i].pm);
            end
            c.coeff_first  = directed_rows[i].c_first;
            c.coeff_second = directed_rows[i].c_second;
            send_item(c, directed_rows[i].typed, directed_rows[i].vals);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:       q = $urandom;
                1:       q = $urandom_range(2, 1 << 16);
                2:       q = 32'h1 << $urandom_range(1, 31);
                default: q = 32'hFFFF_FFFF - $urandom_range(0, 100);
            endcase
            lb = ($urandom_range(0, 7) == 0) ? LOG_W'($urandom_range(0, 31))
                                              : LOG_W'($urandom_range(1, 16));
            // The pressure phase always produces digits so that the block fills up.
            dc = (p != 1 && $urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(0, 15))
                                                       : COUNT_W'($urandom_range(2, 8));
            write_config(q, lb, dc, 1'($urandom_range(0, 1)));
            pressure_go = (p == 1);
            no_gaps     = (p == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                c.coeff_first  = $urandom;
                c.coeff_second = $urandom;
                if (cur_q != 0 && $urandom_range(0, 7) != 0)
                begin
                    c.coeff_first  = c.coeff_first % cur_q;
                    c.coeff_second = c.coeff_second % cur_q;
                end
                send_item(c, 1'b0, '0);
            end
        end
        no_gaps = 1'b0;
        wait_idle();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
